// ----- src/apmc_pkg.sv -----
`default_nettype none

package apmc_pkg;

	localparam int CMD_W = 3;
	localparam int STAMP_W = 32;
	localparam int THR_W = 32;
	localparam int PACK_W = 64;
	localparam int IVL_W = 16;
	localparam int REG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_LOW    = 2'd1,
		MODE_NORMAL = 2'd2,
		MODE_ACTIVE = 2'd3
	} mode_t;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_QUERY    = 3'd0;
	localparam cmd_t CMD_ACTIVITY = 3'd1;
	localparam cmd_t CMD_USER     = 3'd2;
	localparam cmd_t CMD_AUDIO    = 3'd3;
	localparam cmd_t CMD_UPDATE   = 3'd4;
	localparam cmd_t CMD_START    = 3'd5;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_BOOT_PERIOD       = 3'd0;
	localparam reg_idx_t REG_ACTIVE_THRESHOLD  = 3'd1;
	localparam reg_idx_t REG_LOW_THRESHOLD     = 3'd2;
	localparam reg_idx_t REG_IDLE_THRESHOLD    = 3'd3;
	localparam reg_idx_t REG_LOOP_INTERVALS    = 3'd4;
	localparam reg_idx_t REG_ADC_INTERVALS     = 3'd5;
	localparam reg_idx_t REG_DISPLAY_INTERVALS = 3'd6;

	localparam logic [THR_W-1:0] BOOT_PERIOD_RST      = 32'd2000;
	localparam logic [THR_W-1:0] ACTIVE_THRESHOLD_RST = 32'd1000;
	localparam logic [THR_W-1:0] LOW_THRESHOLD_RST    = 32'd5000;
	localparam logic [THR_W-1:0] IDLE_THRESHOLD_RST   = 32'd30000;

	function automatic logic [IVL_W-1:0] pick_interval(input logic [PACK_W-1:0] packed_ivl,
		input mode_t m);
		logic [IVL_W-1:0] r;
		unique case (m)
			MODE_IDLE:   r = packed_ivl[0*IVL_W +: IVL_W];
			MODE_LOW:    r = packed_ivl[1*IVL_W +: IVL_W];
			MODE_NORMAL: r = packed_ivl[2*IVL_W +: IVL_W];
			MODE_ACTIVE: r = packed_ivl[3*IVL_W +: IVL_W];
			default:     r = packed_ivl[0*IVL_W +: IVL_W];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/apmc_if.sv -----
`default_nettype none

interface apmc_evt_if;
	logic                          valid;
	logic                          ready;
	logic [apmc_pkg::CMD_W-1:0]    command;
	logic [apmc_pkg::STAMP_W-1:0]  now_ms;
	logic [apmc_pkg::STAMP_W-1:0]  last_adc_update_ms;
	logic [apmc_pkg::STAMP_W-1:0]  last_display_update_ms;

	modport source(output valid, command, now_ms, last_adc_update_ms, last_display_update_ms,
		input ready);
	modport sink(input valid, command, now_ms, last_adc_update_ms, last_display_update_ms,
		output ready);
endinterface

interface apmc_res_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [apmc_pkg::IVL_W-1:0]  loop_interval;
	logic [apmc_pkg::IVL_W-1:0]  adc_interval;
	logic [apmc_pkg::IVL_W-1:0]  display_interval;
	logic                        adc_due;
	logic                        display_due;

	modport source(output valid, mode, loop_interval, adc_interval, display_interval, adc_due,
		display_due, input ready);
	modport sink(input valid, mode, loop_interval, adc_interval, display_interval, adc_due,
		display_due, output ready);
endinterface

interface apmc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [apmc_pkg::REG_IDX_W-1:0]  index;
	logic [apmc_pkg::PACK_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/activity_power_mode_controller_core.sv -----
`default_nettype none

// Power mode controller driven by timestamped events. Each event transaction
// yields exactly one result transaction. Throughput is one event per cycle
// while the result channel is ready. An event passes the event register, then
// the result register; the mode/timestamp state is updated at the same edge
// that loads the result register, so a following event always sees the state
// left by the one before. Backpressure on the result channel stalls both stages.
// Configuration writes are always ready. TIME_WIDTH sets the width of stored
// timestamps and the modulus of all elapsed-time arithmetic.
module activity_power_mode_controller_core #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	apmc_cfg_if.sink    cfg,
	apmc_evt_if.sink    evt,
	apmc_res_if.source  res
);

	localparam int CW = (TIME_WIDTH > apmc_pkg::STAMP_W) ? TIME_WIDTH : apmc_pkg::STAMP_W;

	// configuration
	logic [apmc_pkg::THR_W-1:0]  boot_period_q;
	logic [apmc_pkg::THR_W-1:0]  active_threshold_q;
	logic [apmc_pkg::THR_W-1:0]  low_threshold_q;
	logic [apmc_pkg::THR_W-1:0]  idle_threshold_q;
	logic [apmc_pkg::PACK_W-1:0] loop_intervals_q;
	logic [apmc_pkg::PACK_W-1:0] adc_intervals_q;
	logic [apmc_pkg::PACK_W-1:0] display_intervals_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_period_q       <= apmc_pkg::BOOT_PERIOD_RST;
			active_threshold_q  <= apmc_pkg::ACTIVE_THRESHOLD_RST;
			low_threshold_q     <= apmc_pkg::LOW_THRESHOLD_RST;
			idle_threshold_q    <= apmc_pkg::IDLE_THRESHOLD_RST;
			loop_intervals_q    <= '0;
			adc_intervals_q     <= '0;
			display_intervals_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				apmc_pkg::REG_BOOT_PERIOD:
					boot_period_q <= cfg.data[apmc_pkg::THR_W-1:0];
				apmc_pkg::REG_ACTIVE_THRESHOLD:
					active_threshold_q <= cfg.data[apmc_pkg::THR_W-1:0];
				apmc_pkg::REG_LOW_THRESHOLD:
					low_threshold_q <= cfg.data[apmc_pkg::THR_W-1:0];
				apmc_pkg::REG_IDLE_THRESHOLD:
					idle_threshold_q <= cfg.data[apmc_pkg::THR_W-1:0];
				apmc_pkg::REG_LOOP_INTERVALS:    loop_intervals_q    <= cfg.data;
				apmc_pkg::REG_ADC_INTERVALS:     adc_intervals_q     <= cfg.data;
				apmc_pkg::REG_DISPLAY_INTERVALS: display_intervals_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// event register
	logic                           valid_s1;
	apmc_pkg::cmd_t                 cmd_s1;
	logic [apmc_pkg::STAMP_W-1:0]   now_s1;
	logic [apmc_pkg::STAMP_W-1:0]   last_adc_s1;
	logic [apmc_pkg::STAMP_W-1:0]   last_disp_s1;

	logic                           valid_s2;
	logic                           advance;

	assign advance   = !valid_s2 || res.ready;
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			cmd_s1       <= evt.command;
			now_s1       <= evt.now_ms;
			last_adc_s1  <= evt.last_adc_update_ms;
			last_disp_s1 <= evt.last_display_update_ms;
		end
	end

	// state
	logic [TIME_WIDTH-1:0]  boot_time_q;
	logic [TIME_WIDTH-1:0]  activity_time_q;
	logic [TIME_WIDTH-1:0]  user_input_time_q;
	apmc_pkg::mode_t        power_mode_q;

	logic [TIME_WIDTH-1:0]  boot_time_d;
	logic [TIME_WIDTH-1:0]  activity_time_d;
	logic [TIME_WIDTH-1:0]  user_input_time_d;
	apmc_pkg::mode_t        power_mode_d;
	apmc_pkg::mode_t        chosen_mode;

	logic [CW-1:0]          now_x;
	logic [CW-1:0]          last_adc_x;
	logic [CW-1:0]          last_disp_x;
	logic [TIME_WIDTH-1:0]  now_t;
	logic [TIME_WIDTH-1:0]  since_boot;
	logic [TIME_WIDTH-1:0]  since_user;
	logic [TIME_WIDTH-1:0]  since_activity;
	logic [TIME_WIDTH-1:0]  since_adc;
	logic [TIME_WIDTH-1:0]  since_disp;

	logic [apmc_pkg::IVL_W-1:0] loop_iv;
	logic [apmc_pkg::IVL_W-1:0] adc_iv;
	logic [apmc_pkg::IVL_W-1:0] disp_iv;
	logic                       adc_due;
	logic                       disp_due;

	always_comb begin
		now_x          = CW'(now_s1);
		last_adc_x     = CW'(last_adc_s1);
		last_disp_x    = CW'(last_disp_s1);
		now_t          = now_x[TIME_WIDTH-1:0];
		since_boot     = now_t - boot_time_q;
		since_user     = now_t - user_input_time_q;
		since_activity = now_t - activity_time_q;
		since_adc      = now_t - last_adc_x[TIME_WIDTH-1:0];
		since_disp     = now_t - last_disp_x[TIME_WIDTH-1:0];
	end

	always_comb begin
		priority if (CW'(since_boot) < CW'(boot_period_q)) begin
			chosen_mode = apmc_pkg::MODE_NORMAL;
		end else if (CW'(since_user) < CW'(active_threshold_q)) begin
			chosen_mode = apmc_pkg::MODE_ACTIVE;
		end else if (CW'(since_activity) < CW'(low_threshold_q)) begin
			chosen_mode = apmc_pkg::MODE_NORMAL;
		end else if (CW'(since_activity) < CW'(idle_threshold_q)) begin
			chosen_mode = apmc_pkg::MODE_LOW;
		end else begin
			chosen_mode = apmc_pkg::MODE_IDLE;
		end
	end

	always_comb begin
		boot_time_d       = boot_time_q;
		activity_time_d   = activity_time_q;
		user_input_time_d = user_input_time_q;
		power_mode_d      = power_mode_q;
		unique case (cmd_s1)
			apmc_pkg::CMD_ACTIVITY: begin
				activity_time_d = now_t;
			end
			apmc_pkg::CMD_USER: begin
				activity_time_d   = now_t;
				user_input_time_d = now_t;
			end
			apmc_pkg::CMD_AUDIO: begin
				if (power_mode_q == apmc_pkg::MODE_IDLE || power_mode_q == apmc_pkg::MODE_LOW) begin
					activity_time_d = now_t;
				end
			end
			apmc_pkg::CMD_UPDATE: begin
				power_mode_d = chosen_mode;
			end
			apmc_pkg::CMD_START: begin
				boot_time_d       = now_t;
				activity_time_d   = now_t;
				user_input_time_d = now_t;
				power_mode_d      = apmc_pkg::MODE_NORMAL;
			end
			default: begin
			end
		endcase

		loop_iv  = apmc_pkg::pick_interval(loop_intervals_q, power_mode_d);
		adc_iv   = apmc_pkg::pick_interval(adc_intervals_q, power_mode_d);
		disp_iv  = apmc_pkg::pick_interval(display_intervals_q, power_mode_d);
		adc_due  = CW'(since_adc) >= CW'(adc_iv);
		disp_due = CW'(since_disp) >= CW'(disp_iv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_time_q       <= '0;
			activity_time_q   <= '0;
			user_input_time_q <= '0;
			power_mode_q      <= apmc_pkg::MODE_NORMAL;
		end else if (advance && valid_s1) begin
			boot_time_q       <= boot_time_d;
			activity_time_q   <= activity_time_d;
			user_input_time_q <= user_input_time_d;
			power_mode_q      <= power_mode_d;
		end
	end

	// result register
	apmc_pkg::mode_t             mode_s2;
	logic [apmc_pkg::IVL_W-1:0]  loop_iv_s2;
	logic [apmc_pkg::IVL_W-1:0]  adc_iv_s2;
	logic [apmc_pkg::IVL_W-1:0]  disp_iv_s2;
	logic                        adc_due_s2;
	logic                        disp_due_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			mode_s2     <= power_mode_d;
			loop_iv_s2  <= loop_iv;
			adc_iv_s2   <= adc_iv;
			disp_iv_s2  <= disp_iv;
			adc_due_s2  <= adc_due;
			disp_due_s2 <= disp_due;
		end
	end

	assign res.valid            = valid_s2;
	assign res.mode             = mode_s2;
	assign res.loop_interval    = loop_iv_s2;
	assign res.adc_interval     = adc_iv_s2;
	assign res.display_interval = disp_iv_s2;
	assign res.adc_due          = adc_due_s2;
	assign res.display_due      = disp_due_s2;

endmodule

`default_nettype wire

// ----- test/tb_activity_power_mode_controller_core.sv -----
`timescale 1ns / 100ps

module tb_activity_power_mode_controller_core;

	localparam apmc_pkg::cmd_t CMD_SPARE6 = 3'd6;
	localparam apmc_pkg::cmd_t CMD_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		apmc_pkg::cmd_t command;
		logic [31:0]    now_ms;
		logic [31:0]    last_adc;
		logic [31:0]    last_disp;
	} evt_item_t;

	typedef struct packed {
		apmc_pkg::mode_t mode;
		logic [15:0]     loop_ivl;
		logic [15:0]     adc_ivl;
		logic [15:0]     disp_ivl;
		logic            adc_due;
		logic            disp_due;
	} res_item_t;

	logic clk;
	logic arst_n;
	logic calm;
	int   cycles;
	int   mismatches;

	evt_item_t pending_events[$];
	res_item_t expected_results[$];

	// power mode state
	logic [31:0]     boot_ms;
	logic [31:0]     act_ms;
	logic [31:0]     user_ms;
	apmc_pkg::mode_t cur_mode;

	// register copies
	logic [31:0] boot_period;
	logic [31:0] active_thr;
	logic [31:0] low_thr;
	logic [31:0] idle_thr;
	logic [63:0] loop_ivls;
	logic [63:0] adc_ivls;
	logic [63:0] disp_ivls;

	logic [31:0] stamp;

	apmc_cfg_if cfg_bus ();
	apmc_evt_if evt ();
	apmc_res_if res ();

	activity_power_mode_controller_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.evt(evt),
		.res(res)
	);

	always #2 clk = ~clk;

	function automatic logic [15:0] mode_field(logic [63:0] packed_ivl, apmc_pkg::mode_t m);
		logic [63:0] shifted;
		shifted = packed_ivl >> (int'(m) * 16);
		return shifted[15:0];
	endfunction

	function automatic apmc_pkg::mode_t next_mode(logic [31:0] now);
		logic [31:0] since_boot;
		logic [31:0] since_user;
		logic [31:0] since_act;
		since_boot = now - boot_ms;
		since_user = now - user_ms;
		since_act = now - act_ms;
		if (since_boot < boot_period) return apmc_pkg::MODE_NORMAL;
		if (since_user < active_thr) return apmc_pkg::MODE_ACTIVE;
		if (since_act < low_thr) return apmc_pkg::MODE_NORMAL;
		if (since_act < idle_thr) return apmc_pkg::MODE_LOW;
		return apmc_pkg::MODE_IDLE;
	endfunction

	function automatic res_item_t apply_event(evt_item_t e);
		res_item_t   r;
		logic [31:0] since_adc;
		logic [31:0] since_disp;
		case (e.command)
			apmc_pkg::CMD_ACTIVITY: act_ms = e.now_ms;
			apmc_pkg::CMD_USER: begin
				user_ms = e.now_ms;
				act_ms = e.now_ms;
			end
			apmc_pkg::CMD_AUDIO: begin
				if (cur_mode == apmc_pkg::MODE_IDLE || cur_mode == apmc_pkg::MODE_LOW)
					act_ms = e.now_ms;
			end
			apmc_pkg::CMD_UPDATE: cur_mode = next_mode(e.now_ms);
			apmc_pkg::CMD_START: begin
				boot_ms = e.now_ms;
				act_ms = e.now_ms;
				user_ms = e.now_ms;
				cur_mode = apmc_pkg::MODE_NORMAL;
			end
			default: ;
		endcase
		r.mode = cur_mode;
		r.loop_ivl = mode_field(loop_ivls, cur_mode);
		r.adc_ivl = mode_field(adc_ivls, cur_mode);
		r.disp_ivl = mode_field(disp_ivls, cur_mode);
		since_adc = e.now_ms - e.last_adc;
		since_disp = e.now_ms - e.last_disp;
		r.adc_due = since_adc >= {16'd0, r.adc_ivl};
		r.disp_due = since_disp >= {16'd0, r.disp_ivl};
		return r;
	endfunction

	function automatic void store_setting(apmc_pkg::reg_idx_t idx, logic [63:0] val);
		case (idx)
			apmc_pkg::REG_BOOT_PERIOD:       boot_period = val[31:0];
			apmc_pkg::REG_ACTIVE_THRESHOLD:  active_thr = val[31:0];
			apmc_pkg::REG_LOW_THRESHOLD:     low_thr = val[31:0];
			apmc_pkg::REG_IDLE_THRESHOLD:    idle_thr = val[31:0];
			apmc_pkg::REG_LOOP_INTERVALS:    loop_ivls = val;
			apmc_pkg::REG_ADC_INTERVALS:     adc_ivls = val;
			apmc_pkg::REG_DISPLAY_INTERVALS: disp_ivls = val;
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s at cycle %0d: expected %0h got %0h", field, cycles, want, got);
	endfunction

	// event driver
	always @(posedge clk) begin : drive_events
		evt_item_t nxt;
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else begin
			if (evt.valid && evt.ready)
				expected_results.push_back(apply_event({evt.command, evt.now_ms,
					evt.last_adc_update_ms, evt.last_display_update_ms}));
			if (!evt.valid || evt.ready) begin
				if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
					nxt = pending_events.pop_front();
					evt.valid <= 1'b1;
					evt.command <= nxt.command;
					evt.now_ms <= nxt.now_ms;
					evt.last_adc_update_ms <= nxt.last_adc;
					evt.last_display_update_ms <= nxt.last_disp;
				end else begin
					evt.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result transaction with nothing expected at cycle %0d", cycles);
				end else begin
					want = expected_results.pop_front();
					if (res.mode !== want.mode) note_mismatch("mode", want.mode, res.mode);
					if (res.loop_interval !== want.loop_ivl)
						note_mismatch("loop_interval", want.loop_ivl, res.loop_interval);
					if (res.adc_interval !== want.adc_ivl)
						note_mismatch("adc_interval", want.adc_ivl, res.adc_interval);
					if (res.display_interval !== want.disp_ivl)
						note_mismatch("display_interval", want.disp_ivl, res.display_interval);
					if (res.adc_due !== want.adc_due)
						note_mismatch("adc_due", want.adc_due, res.adc_due);
					if (res.display_due !== want.disp_due)
						note_mismatch("display_due", want.disp_due, res.display_due);
				end
			end
			res.ready <= calm || $urandom_range(99) >= 15;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic queue_event(apmc_pkg::cmd_t c, logic [31:0] now, logic [31:0] la,
		logic [31:0] ld);
		pending_events.push_back('{c, now, la, ld});
	endtask

	task automatic write_reg(apmc_pkg::reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		store_setting(idx, val);
	endtask

	task automatic wait_quiet();
		bit busy;
		busy = 1'b1;
		while (busy) begin
			@(posedge clk);
			#1;
			busy = pending_events.size() != 0 || evt.valid || expected_results.size() != 0;
		end
	endtask

	task automatic random_setup(output int unsigned span, output int unsigned ivl_span);
		logic [31:0] bp;
		logic [31:0] at;
		logic [31:0] lt;
		logic [31:0] it;
		logic [63:0] pk[3];
		int unsigned ivl_max;
		case ($urandom_range(3))
			0: ivl_max = 100;
			1: ivl_max = 2000;
			2: ivl_max = 30000;
			default: ivl_max = 65535;
		endcase
		bp = $urandom_range(3000);
		at = $urandom_range(2000);
		lt = $urandom_range(6000);
		it = $urandom_range(1) ? lt + $urandom_range(25000) : $urandom_range(30000);
		if ($urandom_range(4) == 0) begin
			bp = $urandom;
			at = $urandom;
			lt = $urandom;
			it = $urandom;
		end
		for (int k = 0; k < 3; k++)
			for (int f = 0; f < 4; f++)
				pk[k][f*16 +: 16] = $urandom_range(ivl_max);
		write_reg(apmc_pkg::REG_BOOT_PERIOD, {32'd0, bp});
		write_reg(apmc_pkg::REG_ACTIVE_THRESHOLD, {32'd0, at});
		write_reg(apmc_pkg::REG_LOW_THRESHOLD, {32'd0, lt});
		write_reg(apmc_pkg::REG_IDLE_THRESHOLD, {32'd0, it});
		write_reg(apmc_pkg::REG_LOOP_INTERVALS, pk[0]);
		write_reg(apmc_pkg::REG_ADC_INTERVALS, pk[1]);
		write_reg(apmc_pkg::REG_DISPLAY_INTERVALS, pk[2]);
		span = (it > 60000) ? 60000 : it + 500;
		ivl_span = ivl_max + ivl_max / 2 + 1;
	endtask

	task automatic fill_random(int count, int unsigned span, int unsigned ivl_span);
		int unsigned    roll;
		apmc_pkg::cmd_t c;
		logic [31:0]    la;
		logic [31:0]    ld;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 15) c = apmc_pkg::CMD_ACTIVITY;
			else if (roll < 30) c = apmc_pkg::CMD_USER;
			else if (roll < 50) c = apmc_pkg::CMD_AUDIO;
			else if (roll < 85) c = apmc_pkg::CMD_UPDATE;
			else if (roll < 94) c = apmc_pkg::CMD_QUERY;
			else if (roll < 96) c = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
			else c = apmc_pkg::CMD_START;
			// occasional jump breaks the time sequence
			if ($urandom_range(19) == 0) stamp = $urandom;
			else if ($urandom_range(1)) stamp += $urandom_range(span / 8);
			else stamp += $urandom_range(span);
			la = ($urandom_range(9) == 0) ? $urandom : stamp - $urandom_range(ivl_span);
			ld = ($urandom_range(9) == 0) ? $urandom : stamp - $urandom_range(ivl_span);
			queue_event(c, stamp, la, ld);
		end
	endtask

	initial begin : stimulus
		int unsigned span;
		int unsigned ivl_span;
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		cycles = 0;
		mismatches = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		evt.valid = 1'b0;
		evt.command = '0;
		evt.now_ms = '0;
		evt.last_adc_update_ms = '0;
		evt.last_display_update_ms = '0;
		res.ready = 1'b0;
		boot_ms = '0;
		act_ms = '0;
		user_ms = '0;
		cur_mode = apmc_pkg::MODE_NORMAL;
		boot_period = apmc_pkg::BOOT_PERIOD_RST;
		active_thr = apmc_pkg::ACTIVE_THRESHOLD_RST;
		low_thr = apmc_pkg::LOW_THRESHOLD_RST;
		idle_thr = apmc_pkg::IDLE_THRESHOLD_RST;
		loop_ivls = '0;
		adc_ivls = '0;
		disp_ivls = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: updates before any start, mode walk, audio gating, wrap
		queue_event(apmc_pkg::CMD_UPDATE, 32'd500, 32'd0, 32'hFFFF_FFFF);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd2500, 32'hFFFF_FFFF, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd10000, 32'd10000, 32'd10001);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd40000, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_AUDIO, 32'd40010, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd40020, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_AUDIO, 32'd41000, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd46000, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_AUDIO, 32'd46001, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd46002, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_USER, 32'd50000, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd50500, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		queue_event(CMD_SPARE6, 32'd0, 32'hFFFF_FFFF, 32'd0);
		queue_event(CMD_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_event(apmc_pkg::CMD_START, 32'hFFFF_FF00, 32'd0, 32'd0);
		queue_event(apmc_pkg::CMD_UPDATE, 32'h0000_0100, 32'hFFFF_FFF0, 32'd0);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// zero thresholds, distinct intervals per mode
		write_reg(apmc_pkg::REG_BOOT_PERIOD, 64'd0);
		write_reg(apmc_pkg::REG_ACTIVE_THRESHOLD, 64'd0);
		write_reg(apmc_pkg::REG_LOW_THRESHOLD, 64'd0);
		write_reg(apmc_pkg::REG_IDLE_THRESHOLD, 64'd0);
		write_reg(apmc_pkg::REG_LOOP_INTERVALS, 64'h0004_0003_0002_0001);
		write_reg(apmc_pkg::REG_ADC_INTERVALS, 64'h0190_012C_00C8_0064);
		write_reg(apmc_pkg::REG_DISPLAY_INTERVALS, 64'h0028_001E_0014_000A);
		queue_event(apmc_pkg::CMD_START, 32'd1000, 32'd700, 32'd971);
		queue_event(apmc_pkg::CMD_UPDATE, 32'd1000, 32'd900, 32'd991);
		queue_event(apmc_pkg::CMD_AUDIO, 32'd1005, 32'd906, 32'd995);
		queue_event(apmc_pkg::CMD_QUERY, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FF00);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// all-ones thresholds and intervals
		write_reg(apmc_pkg::REG_BOOT_PERIOD, 64'hFFFF_FFFF);
		write_reg(apmc_pkg::REG_ACTIVE_THRESHOLD, 64'hFFFF_FFFF);
		write_reg(apmc_pkg::REG_LOW_THRESHOLD, 64'hFFFF_FFFF);
		write_reg(apmc_pkg::REG_IDLE_THRESHOLD, 64'hFFFF_FFFF);
		write_reg(apmc_pkg::REG_LOOP_INTERVALS, '1);
		write_reg(apmc_pkg::REG_ADC_INTERVALS, '1);
		write_reg(apmc_pkg::REG_DISPLAY_INTERVALS, '1);
		queue_event(apmc_pkg::CMD_START, 32'd0, 32'hFFFF_0001, 32'hFFFF_0002);
		queue_event(apmc_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_0001);
		queue_event(apmc_pkg::CMD_UPDATE, 32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF);
		queue_event(apmc_pkg::CMD_USER, 32'd5, 32'hFFFF_0006, 32'd5);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		for (int p = 0; p < 10; p++) begin
			random_setup(span, ivl_span);
			calm = (p == 5);
			if (p % 3 == 0) stamp = 32'hFFFF_FFFF - $urandom_range(20000);
			else stamp = $urandom;
			queue_event(apmc_pkg::CMD_START, stamp, stamp, stamp);
			if (p == 3) begin
				// sender holds off until everything has drained
				fill_random(70, span, ivl_span);
				wait_quiet();
				fill_random(71, span, ivl_span);
			end else begin
				fill_random(141, span, ivl_span);
			end
			wait_quiet();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- activity_power_mode_controller_core.f -----
src/apmc_pkg.sv
src/apmc_if.sv
src/activity_power_mode_controller_core.sv
test/tb_activity_power_mode_controller_core.sv
